/* hw/rtl/nearest_periodic_image_search_top_defines.svh */
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef NEAREST_PERIODIC_IMAGE_SEARCH_TOP_DEFINES_SVH
`define NEAREST_PERIODIC_IMAGE_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication.
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NPS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/nps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest periodic image search block.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int NCAND      = 27;
   localparam int POS_W      = 24;
   localparam int DIFF_W     = 25;
   localparam int BASE_W     = 8;
   localparam int PER_W      = 8;
   localparam int IMG_W      = 10;
   localparam int D_W        = 31;
   localparam int LAT_W      = 21;
   localparam int PROD_W     = 52;
   localparam int SUM_W      = 54;
   localparam int CART_W     = 44;
   localparam int DIST_W     = 62;
   localparam int TOL_W      = 32;
   localparam int ROW_W      = 63;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 63;
   localparam int CNT_W      = 5;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_A  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_B  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_C  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_A  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_B  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_C  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL    = 4'd7;

   // Ternary step codes for one image axis.
   localparam logic [1:0] STEP_NEG  = 2'd0;
   localparam logic [1:0] STEP_ZERO = 2'd1;
   localparam logic [1:0] STEP_POS  = 2'd2;

   typedef struct packed {
      logic [2:0][ROW_W-1:0] lat;
      logic [2:0][PER_W-1:0] per;
      logic                  mode;
      logic [TOL_W-1:0]      tol;
   } cfg_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] diff;
      logic [2:0][BASE_W-1:0] base;
   } item_type;

   typedef struct packed {
      logic                  first;
      logic                  lastc;
      logic [2:0][IMG_W-1:0] img;
   } tag_type;

   typedef struct packed {
      logic              valid;
      tag_type           tag;
      logic [DIST_W-1:0] dsq;
   } cand_type;

   typedef struct packed {
      logic [2:0][IMG_W-1:0] img;
      logic [DIST_W-1:0]     dsq;
      logic                  last;
   } result_type;

endpackage

/* hw/rtl/nps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_front
// Accepts position pairs, forms the fractional differences and holds them in
// a two-entry queue for the candidate engine.
// ----------------------------------------------------------------------------
module nps_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic signed [nps_pkg::POS_W-1:0]  pos_i_a,
   input  logic signed [nps_pkg::POS_W-1:0]  pos_i_b,
   input  logic signed [nps_pkg::POS_W-1:0]  pos_i_c,
   input  logic signed [nps_pkg::POS_W-1:0]  pos_j_a,
   input  logic signed [nps_pkg::POS_W-1:0]  pos_j_b,
   input  logic signed [nps_pkg::POS_W-1:0]  pos_j_c,
   input  logic signed [nps_pkg::BASE_W-1:0] base_a,
   input  logic signed [nps_pkg::BASE_W-1:0] base_b,
   input  logic signed [nps_pkg::BASE_W-1:0] base_c,
   output logic                           item_valid,
   output nps_pkg::item_type              item,
   input  logic                           item_take
);
   import nps_pkg::*;

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   new_item;
   logic       do_push, do_pop;

   // Differences are formed on the way in.
   always_comb begin
      new_item.diff[0] = DIFF_W'(pos_i_a) - DIFF_W'(pos_j_a);
      new_item.diff[1] = DIFF_W'(pos_i_b) - DIFF_W'(pos_j_b);
      new_item.diff[2] = DIFF_W'(pos_i_c) - DIFF_W'(pos_j_c);
      new_item.base[0] = base_a;
      new_item.base[1] = base_b;
      new_item.base[2] = base_c;
   end

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   // Queue pointers and fill count.
   always_comb begin
      wptr_in = do_push ? !wptr_ff : wptr_ff;
      rptr_in = do_pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= new_item;
      end
   end

endmodule

/* hw/rtl/nps_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_eval
// Steps through the 27 images of one item, one per cycle, and computes the
// saturated squared Cartesian distance of each in a five-stage pipeline.
// ----------------------------------------------------------------------------
module nps_eval (
   input  logic              clock,
   input  logic              reset,
   input  nps_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  nps_pkg::item_type item,
   output logic              item_take,
   input  logic              bank_avail,
   output nps_pkg::cand_type cand
);
   import nps_pkg::*;

   // Sequencer state.
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       si_ff, si_in, sj_ff, sj_in, sk_ff, sk_in;
   item_type         cur_ff;
   logic             at_end;

   // Pipeline registers.
   logic                              v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   tag_type                           t0_ff, t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [D_W-1:0]             d0_ff [3];
   logic signed [PROD_W-1:0]          p1_ff [3][3];
   logic signed [CART_W-1:0]          c2_ff [3];
   logic [2:0]                        sat3_ff;
   logic [2*(LAT_W-1)-1:0]            hh3_ff [3];
   logic [2*LAT_W-2:0]                hl3_ff [3];
   logic [2*LAT_W-1:0]                ll3_ff [3];
   logic [DIST_W-1:0]                 dist4_ff;

   logic signed [D_W-1:0]    d0_in [3];
   tag_type                  t0_in;
   logic [1:0]               step [3];

   assign at_end    = (cnt_ff == CNT_W'(NCAND - 1));
   assign item_take = item_valid && bank_avail && (!busy_ff || at_end);

   // Candidate sequencer: k steps fastest, then j, then i.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      si_in   = si_ff;
      sj_in   = sj_ff;
      sk_in   = sk_ff;
      if (item_take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         si_in   = STEP_NEG;
         sj_in   = STEP_NEG;
         sk_in   = STEP_NEG;
      end else if (busy_ff && at_end) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (sk_ff == STEP_POS) begin
            sk_in = STEP_NEG;
            if (sj_ff == STEP_POS) begin
               sj_in = STEP_NEG;
               si_in = si_ff + 1'b1;
            end else begin
               sj_in = sj_ff + 1'b1;
            end
         end else begin
            sk_in = sk_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         si_ff   <= STEP_NEG;
         sj_ff   <= STEP_NEG;
         sk_ff   <= STEP_NEG;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         si_ff   <= si_in;
         sj_ff   <= sj_in;
         sk_ff   <= sk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         cur_ff <= item;
      end
   end

   // Image cell and fractional difference for the current candidate.
   always_comb begin
      logic signed [IMG_W-1:0] per_s;
      logic signed [IMG_W-1:0] r;
      step[0] = si_ff;
      step[1] = sj_ff;
      step[2] = sk_ff;
      t0_in.first = (cnt_ff == '0);
      t0_in.lastc = at_end;
      for (int a = 0; a < 3; a++) begin
         per_s = $signed({2'b00, cfg.per[a]});
         case (step[a])
            STEP_NEG: r = IMG_W'($signed(cur_ff.base[a])) - per_s;
            STEP_POS: r = IMG_W'($signed(cur_ff.base[a])) + per_s;
            default:  r = IMG_W'($signed(cur_ff.base[a]));
         endcase
         t0_in.img[a] = r;
         d0_in[a] = D_W'($signed(cur_ff.diff[a])) - (D_W'(r) <<< 20);
      end
   end

   // Stage 0: candidate.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= busy_ff;
      end
      t0_ff <= t0_in;
      for (int a = 0; a < 3; a++) begin
         d0_ff[a] <= d0_in[a];
      end
   end

   // Stage 1: the nine lattice products.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      t1_ff <= t0_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p1_ff[r][c] <= PROD_W'(d0_ff[r] *
                           $signed(cfg.lat[r][c*LAT_W +: LAT_W]));
         end
      end
   end

   // Stage 2: column sums, rounded half up to 20 fractional bits.
   always_ff @(posedge clock) begin
      logic signed [SUM_W-1:0] s;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      t2_ff <= t1_ff;
      for (int c = 0; c < 3; c++) begin
         s = SUM_W'(p1_ff[0][c]) + SUM_W'(p1_ff[1][c]) + SUM_W'(p1_ff[2][c])
             + SUM_W'(512);
         c2_ff[c] <= s[SUM_W-1:10];
      end
   end

   // Stage 3: split magnitude into high and low halves and square them.
   always_ff @(posedge clock) begin
      logic [CART_W-1:0] mag;
      logic [19:0]       h;
      logic [20:0]       l;
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      t3_ff <= t2_ff;
      for (int c = 0; c < 3; c++) begin
         mag = c2_ff[c][CART_W-1] ? CART_W'(-c2_ff[c]) : CART_W'(c2_ff[c]);
         h   = mag[40:21];
         l   = mag[20:0];
         sat3_ff[c] <= |mag[CART_W-1:41];
         hh3_ff[c]  <= h * h;
         hl3_ff[c]  <= h * l;
         ll3_ff[c]  <= l * l;
      end
   end

   // Stage 4: assemble the squares and take the saturating sum.
   always_ff @(posedge clock) begin
      logic [63:0] sq;
      logic [63:0] tot;
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      t4_ff <= t3_ff;
      tot = '0;
      for (int c = 0; c < 3; c++) begin
         sq = (64'(hh3_ff[c]) << 22) + (64'(hl3_ff[c]) << 2) + (64'(ll3_ff[c]) >> 20);
         if (sat3_ff[c] || sq > 64'(DIST_MAX)) begin
            sq = 64'(DIST_MAX);
         end
         tot = tot + sq;
      end
      dist4_ff <= (tot > 64'(DIST_MAX)) ? DIST_MAX : tot[DIST_W-1:0];
   end

   assign cand.valid = v4_ff;
   assign cand.tag   = t4_ff;
   assign cand.dsq   = dist4_ff;

endmodule

/* hw/rtl/nps_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_select
// Keeps the minimum or the tie list of each item in one of two list banks
// and drains finished banks into a four-entry result queue.
// ----------------------------------------------------------------------------
module nps_select (
   input  logic                clock,
   input  logic                reset,
   input  nps_pkg::cfg_type    cfg,
   input  nps_pkg::cand_type   cand,
   input  logic                start,
   output logic                bank_avail,
   input  logic                pop,
   output logic                empty,
   output nps_pkg::result_type result
);
   import nps_pkg::*;

   localparam int ENTRY_W = 3 * IMG_W + DIST_W;

   // List banks: bank bit on top, list position below.
   logic [ENTRY_W-1:0] bank_mem [2 * (1 << CNT_W)];

   // Writer side.
   logic [DIST_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]  wptr_ff, wptr_in;
   logic              wbank_ff, wbank_in;
   logic              restart, append, wr_en;
   logic [CNT_W:0]    wr_addr;
   logic [DIST_W:0]   dist_tol;
   logic [DIST_W-1:0] adiff;

   // Bank bookkeeping.
   logic [1:0]       full_ff, full_in;
   logic [CNT_W-1:0] len_ff [2];
   logic [1:0]       res_ff, res_in;

   // Reader side.
   logic             rbank_ff, rbank_in;
   logic [CNT_W-1:0] rptr_ff, rptr_in;
   logic             issue, rlast;
   logic             infl_ff, rl_ff;
   logic [ENTRY_W-1:0] rd_ff;

   // Result queue.
   result_type q_ff [4];
   logic [1:0] qw_ff, qr_ff;
   logic [2:0] qcnt_ff, qcnt_in;
   logic       qpop;

   // Minimum and tie decisions for the incoming candidate.
   always_comb begin
      dist_tol = {1'b0, cand.dsq} + (DIST_W + 1)'(cfg.tol);
      adiff    = (cand.dsq > best_ff) ? cand.dsq - best_ff : best_ff - cand.dsq;
      if (cfg.mode) begin
         restart = cand.tag.first || (dist_tol < {1'b0, best_ff});
         append  = !restart && (adiff <= DIST_W'(cfg.tol));
      end else begin
         restart = cand.tag.first || (cand.dsq < best_ff);
         append  = 1'b0;
      end
      wr_en   = cand.valid && (restart || append);
      wr_addr = {wbank_ff, restart ? CNT_W'(0) : wptr_ff};
      best_in  = (cand.valid && restart) ? cand.dsq : best_ff;
      wptr_in  = wptr_ff;
      wbank_in = wbank_ff;
      if (cand.valid && restart) begin
         wptr_in = CNT_W'(1);
      end else if (cand.valid && append) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (cand.valid && cand.tag.lastc) begin
         wbank_in = !wbank_ff;
      end
   end

   // Reader issue: keep the queue plus the read in flight within four.
   assign issue = full_ff[rbank_ff] && ((qcnt_ff + 3'(infl_ff)) < 3'd4);
   assign rlast = (rptr_ff == len_ff[rbank_ff] - 1'b1);

   always_comb begin
      rptr_in  = rptr_ff;
      rbank_in = rbank_ff;
      full_in  = full_ff;
      if (cand.valid && cand.tag.lastc) begin
         full_in[wbank_ff] = 1'b1;
      end
      if (issue) begin
         if (rlast) begin
            rptr_in = '0;
            rbank_in = !rbank_ff;
            full_in[rbank_ff] = 1'b0;
         end else begin
            rptr_in = rptr_ff + 1'b1;
         end
      end
      res_in = res_ff + 2'(start) - 2'(issue && rlast);
   end

   assign bank_avail = (res_ff != 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         wbank_ff <= 1'b0;
         full_ff  <= '0;
         res_ff   <= '0;
         rptr_ff  <= '0;
         rbank_ff <= 1'b0;
         infl_ff  <= 1'b0;
      end else begin
         wptr_ff  <= wptr_in;
         wbank_ff <= wbank_in;
         full_ff  <= full_in;
         res_ff   <= res_in;
         rptr_ff  <= rptr_in;
         rbank_ff <= rbank_in;
         infl_ff  <= issue;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      if (cand.valid && cand.tag.lastc) begin
         len_ff[wbank_ff] <= wptr_in;
      end
   end

   // List bank write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_mem[wr_addr] <= {cand.tag.img, cand.dsq};
      end
      if (issue) begin
         rd_ff <= bank_mem[{rbank_ff, rptr_ff}];
         rl_ff <= rlast;
      end
   end

   // Result queue.
   assign empty   = (qcnt_ff == 3'd0);
   assign qpop    = pop && !empty;
   assign result  = q_ff[qr_ff];
   assign qcnt_in = qcnt_ff + 3'(infl_ff) - 3'(qpop);

   always_ff @(posedge clock) begin
      if (reset) begin
         qw_ff   <= '0;
         qr_ff   <= '0;
         qcnt_ff <= '0;
      end else begin
         qw_ff   <= qw_ff + 2'(infl_ff);
         qr_ff   <= qr_ff + 2'(qpop);
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (infl_ff) begin
         q_ff[qw_ff].img  <= rd_ff[ENTRY_W-1:DIST_W];
         q_ff[qw_ff].dsq  <= rd_ff[DIST_W-1:0];
         q_ff[qw_ff].last <= rl_ff;
      end
   end

endmodule

/* hw/rtl/nearest_periodic_image_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_periodic_image_search_top
// Minimum-image search over the 27 neighbor images of a periodic supercell.
//
//  channel | direction | handshake             | transfer
//  req_    | in        | req_push / req_full   | position pair and base cell
//  rsp_    | out       | rsp_pop / rsp_empty   | image cell, distance, last
//  csr_    | in        | csr_we                | register write, no wait
//
// The candidate engine takes one image of an item per cycle, so items stream
// in back to back while result lists hold at most 21 entries and responses
// are popped freely; with longer lists an item waits for the bank of the
// item two ahead. The first result is ready once the item's last image has
// left the pipeline, its bank is marked full and its first entry is read
// and queued; results drain at one per cycle while rsp_pop is held high.
// Reset is synchronous and clears all control state; the block is ready at
// once. Either side may stall freely: a two-entry input queue, two list
// banks and a four-entry result queue decouple the front from the back.
// ----------------------------------------------------------------------------
module nearest_periodic_image_search_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [nps_pkg::POS_W-1:0]     req_pos_i_a,
   input  logic signed [nps_pkg::POS_W-1:0]     req_pos_i_b,
   input  logic signed [nps_pkg::POS_W-1:0]     req_pos_i_c,
   input  logic signed [nps_pkg::POS_W-1:0]     req_pos_j_a,
   input  logic signed [nps_pkg::POS_W-1:0]     req_pos_j_b,
   input  logic signed [nps_pkg::POS_W-1:0]     req_pos_j_c,
   input  logic signed [nps_pkg::BASE_W-1:0]    req_base_cell_a,
   input  logic signed [nps_pkg::BASE_W-1:0]    req_base_cell_b,
   input  logic signed [nps_pkg::BASE_W-1:0]    req_base_cell_c,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [nps_pkg::IMG_W-1:0]     rsp_image_a,
   output logic signed [nps_pkg::IMG_W-1:0]     rsp_image_b,
   output logic signed [nps_pkg::IMG_W-1:0]     rsp_image_c,
   output logic [nps_pkg::DIST_W-1:0]           rsp_dist_sq,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [nps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nps_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import nps_pkg::*;

   cfg_type    cfg_ff;
   item_type   item;
   logic       item_valid, item_take, bank_avail;
   cand_type   cand;
   result_type result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lat  <= '0;
         cfg_ff.per  <= {3{PER_W'(1)}};
         cfg_ff.mode <= 1'b0;
         cfg_ff.tol  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAT_A: cfg_ff.lat[0] <= csr_wdata;
            CSR_LAT_B: cfg_ff.lat[1] <= csr_wdata;
            CSR_LAT_C: cfg_ff.lat[2] <= csr_wdata;
            CSR_PER_A: cfg_ff.per[0] <= csr_wdata[PER_W-1:0];
            CSR_PER_B: cfg_ff.per[1] <= csr_wdata[PER_W-1:0];
            CSR_PER_C: cfg_ff.per[2] <= csr_wdata[PER_W-1:0];
            CSR_MODE:  cfg_ff.mode   <= csr_wdata[0];
            CSR_TOL:   cfg_ff.tol    <= csr_wdata[TOL_W-1:0];
            default:   ;
         endcase
      end
   end

   nps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .pos_i_a    (req_pos_i_a),
      .pos_i_b    (req_pos_i_b),
      .pos_i_c    (req_pos_i_c),
      .pos_j_a    (req_pos_j_a),
      .pos_j_b    (req_pos_j_b),
      .pos_j_c    (req_pos_j_c),
      .base_a     (req_base_cell_a),
      .base_b     (req_base_cell_b),
      .base_c     (req_base_cell_c),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   nps_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .bank_avail (bank_avail),
      .cand       (cand)
   );

   nps_select u_select (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cand       (cand),
      .start      (item_take),
      .bank_avail (bank_avail),
      .pop        (rsp_pop),
      .empty      (rsp_empty),
      .result     (result)
   );

   assign rsp_image_a = result.img[0];
   assign rsp_image_b = result.img[1];
   assign rsp_image_c = result.img[2];
   assign rsp_dist_sq = result.dsq;
   assign rsp_last    = result.last;

endmodule

/* hw/rtl/nps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks of the nearest periodic image search block.
// ----------------------------------------------------------------------------
`include "nearest_periodic_image_search_top_defines.svh"

module nps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_push,
   input logic                              req_full,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input logic [nps_pkg::IMG_W-1:0]         rsp_image_a,
   input logic [nps_pkg::DIST_W-1:0]        rsp_dist_sq,
   input logic                              rsp_last
);

   // A waiting result is not withdrawn.
   `NPS_ASSERT_NXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty, "result withdrawn")

   // A waiting result keeps its payload.
   `NPS_ASSERT_NXT(a_rsp_stable, !rsp_empty && !rsp_pop,
      $stable(rsp_dist_sq) && $stable(rsp_image_a) && $stable(rsp_last), "result changed")

   // Leaving reset, no results wait and the input side is open.
   `NPS_ASSERT_IMP(a_reset_state, $fell(reset), rsp_empty && !req_full, "bad state after reset")

   // The input queue fills only through a transfer.
   `NPS_ASSERT_NXT(a_full_cause, !req_push, !$rose(req_full), "full without transfer")

endmodule

bind nearest_periodic_image_search_top nps_checker u_nps_checker (.*);

/* tb/sv/nearest_periodic_image_search_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_periodic_image_search_top_tb
// Self-checking bench for the 27-neighbor minimum-image search. A scoreboard
// class predicts every image and distance for each accepted request, in both
// the single-nearest and the tie-list modes, and checks each response field
// by field. Several lattice and period settings are applied while idle,
// under changing request idling and response stall patterns.
// ----------------------------------------------------------------------------
module nearest_periodic_image_search_top_tb;
   import nps_pkg::*;

   localparam logic MODE_SINGLE = 1'b0;
   localparam logic MODE_TIES   = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;
   localparam int   SETTLE      = 60;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd11;

   typedef struct packed {
      logic [2:0][POS_W-1:0]  pos_i;
      logic [2:0][POS_W-1:0]  pos_j;
      logic [2:0][BASE_W-1:0] base;
   } pair_type;

   typedef struct packed {
      logic [2:0][IMG_W-1:0] img;
      logic [DIST_W-1:0]     dsq;
      logic                  last;
   } image_type;

   // Holds the register copy and the images still to come back.
   class image_scoreboard;
      logic [2:0][ROW_W-1:0] rows;
      logic [2:0][PER_W-1:0] per;
      logic                  mode;
      logic [TOL_W-1:0]      tol;
      image_type             pending_images[$];
      int                    errors;

      function new();
         rows = '0;
         per = {3{8'd1}};
         mode = MODE_SINGLE;
         tol = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LAT_A: rows[0] = data;
            CSR_LAT_B: rows[1] = data;
            CSR_LAT_C: rows[2] = data;
            CSR_PER_A: per[0] = data[PER_W-1:0];
            CSR_PER_B: per[1] = data[PER_W-1:0];
            CSR_PER_C: per[2] = data[PER_W-1:0];
            CSR_MODE:  mode = data[0];
            CSR_TOL:   tol = data[TOL_W-1:0];
            default: ;
         endcase
      endfunction

      // Squared component, floored to 20 fractional bits and saturated.
      function logic [63:0] square_q20(longint cart);
         logic [63:0]  mag;
         logic [127:0] sq;
         mag = (cart < 0) ? -cart : cart;
         sq = (128'(mag) * 128'(mag)) >> 20;
         return (sq > 128'(DIST_MAX)) ? {2'b00, DIST_MAX} : sq[63:0];
      endfunction

      // Scans the 27 images of one request and queues the chosen ones.
      function void note_request(pair_type p);
         longint      lat[3][3];
         longint      diff[3];
         longint      img_cell[3];
         longint      d[3];
         longint      sum;
         longint      cart;
         logic [63:0] sq_sum;
         logic [63:0] best;
         logic [63:0] gap;
         image_type   cand[27];
         bit          keep[27];
         int          n;
         int          pick;
         int          kept;
         best = 0;
         n = 0;
         pick = 0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               lat[r][c] = longint'($signed(rows[r][c*LAT_W +: LAT_W]));
            end
         end
         for (int k = 0; k < 3; k++) begin
            diff[k] = longint'($signed(p.pos_i[k])) - longint'($signed(p.pos_j[k]));
         end
         for (int i = -1; i <= 1; i++) begin
            for (int j = -1; j <= 1; j++) begin
               for (int m = -1; m <= 1; m++) begin
                  img_cell[0] = longint'($signed(p.base[0])) + i * longint'(per[0]);
                  img_cell[1] = longint'($signed(p.base[1])) + j * longint'(per[1]);
                  img_cell[2] = longint'($signed(p.base[2])) + m * longint'(per[2]);
                  for (int k = 0; k < 3; k++) d[k] = diff[k] - (img_cell[k] <<< 20);
                  sq_sum = 0;
                  for (int c = 0; c < 3; c++) begin
                     sum = d[0] * lat[0][c] + d[1] * lat[1][c] + d[2] * lat[2][c];
                     // Round half up to 20 fractional bits.
                     cart = (sum + 512) >>> 10;
                     sq_sum = sq_sum + square_q20(cart);
                     if (sq_sum > 64'(DIST_MAX)) sq_sum = 64'(DIST_MAX);
                  end
                  for (int k = 0; k < 3; k++) cand[n].img[k] = img_cell[k][IMG_W-1:0];
                  cand[n].dsq = sq_sum[DIST_W-1:0];
                  cand[n].last = 1'b0;
                  keep[n] = 1'b0;
                  if (mode == MODE_SINGLE) begin
                     if (n == 0 || sq_sum < best) begin
                        best = sq_sum;
                        pick = n;
                     end
                  end else if (n == 0 || sq_sum + 64'(tol) < best) begin
                     // A clearly closer image restarts the tie list.
                     for (int q = 0; q < n; q++) keep[q] = 1'b0;
                     keep[n] = 1'b1;
                     best = sq_sum;
                  end else begin
                     gap = (sq_sum > best) ? sq_sum - best : best - sq_sum;
                     if (gap <= 64'(tol)) keep[n] = 1'b1;
                  end
                  n++;
               end
            end
         end
         if (mode == MODE_SINGLE) begin
            for (int q = 0; q < 27; q++) keep[q] = (q == pick);
         end
         kept = 0;
         for (int q = 0; q < 27; q++) begin
            if (keep[q]) kept++;
         end
         for (int q = 0; q < 27; q++) begin
            if (keep[q]) begin
               kept--;
               cand[q].last = (kept == 0);
               pending_images = {pending_images, cand[q]};
            end
         end
      endfunction

      function void check_response(image_type got);
         image_type want;
         if (pending_images.size() == 0) begin
            $display("%0t: response with nothing expected: img %h dist %h last %b",
                     $realtime, got.img, got.dsq, got.last);
            errors++;
            return;
         end
         want = pending_images.pop_front();
         for (int k = 0; k < 3; k++) begin
            if (got.img[k] !== want.img[k]) begin
               $display("%0t: image axis %0d expected %0d actual %0d", $realtime, k,
                        $signed(want.img[k]), $signed(got.img[k]));
               errors++;
            end
         end
         if (got.dsq !== want.dsq) begin
            $display("%0t: dist_sq expected %h actual %h", $realtime, want.dsq, got.dsq);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $realtime, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic [2:0][POS_W-1:0]   req_pos_i = '0;
   logic [2:0][POS_W-1:0]   req_pos_j = '0;
   logic [2:0][BASE_W-1:0]  req_base = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic [IMG_W-1:0]        rsp_image_a;
   logic [IMG_W-1:0]        rsp_image_b;
   logic [IMG_W-1:0]        rsp_image_c;
   logic [DIST_W-1:0]       rsp_dist_sq;
   logic                    rsp_last;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   image_scoreboard sb = new();
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              cycles = 0;

   nearest_periodic_image_search_top uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_pos_i_a(req_pos_i[0]), .req_pos_i_b(req_pos_i[1]), .req_pos_i_c(req_pos_i[2]),
      .req_pos_j_a(req_pos_j[0]), .req_pos_j_b(req_pos_j[1]), .req_pos_j_c(req_pos_j[2]),
      .req_base_cell_a(req_base[0]), .req_base_cell_b(req_base[1]),
      .req_base_cell_c(req_base[2]),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_image_a(rsp_image_a), .rsp_image_b(rsp_image_b), .rsp_image_c(rsp_image_c),
      .rsp_dist_sq(rsp_dist_sq), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run-away guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** nearest_periodic_image_search_top: FAILED **");
         $finish;
      end
   end

   // Response side: check each transfer, then pick the next pop at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            sb.check_response({rsp_image_c, rsp_image_b, rsp_image_a, rsp_dist_sq, rsp_last});
         end
         rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // One register write per cycle; the caller lowers csr_we afterwards.
   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic send_pair(pair_type p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_pos_i <= p.pos_i;
      req_pos_j <= p.pos_j;
      req_base <= p.base;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(p);
   endtask

   function automatic pair_type make_pair(longint ia, longint ib, longint ic, longint ja,
                                          longint jb, longint jc, int ba, int bb, int bc);
      pair_type p;
      p.pos_i = {ic[POS_W-1:0], ib[POS_W-1:0], ia[POS_W-1:0]};
      p.pos_j = {jc[POS_W-1:0], jb[POS_W-1:0], ja[POS_W-1:0]};
      p.base = {bc[BASE_W-1:0], bb[BASE_W-1:0], ba[BASE_W-1:0]};
      return p;
   endfunction

   // Mostly near-tie geometry around small base cells, some fully random pairs.
   function automatic pair_type random_pair();
      pair_type p;
      longint   pj;
      longint   shift;
      int       b;
      if ($urandom_range(99) < 30) begin
         for (int k = 0; k < 3; k++) begin
            p.pos_i[k] = POS_W'($urandom);
            p.pos_j[k] = POS_W'($urandom);
            p.base[k] = BASE_W'($urandom);
         end
         return p;
      end
      for (int k = 0; k < 3; k++) begin
         b = $urandom_range(6) - 3;
         pj = longint'($urandom_range(4194303)) - 2097152;
         case ($urandom_range(3))
            0: shift = 0;
            1: shift = longint'(sb.per[k]) <<< 19;
            2: shift = -(longint'(sb.per[k]) <<< 19);
            default: shift = longint'($urandom_range(524287)) - 262144;
         endcase
         p.pos_j[k] = pj[POS_W-1:0];
         pj = pj + (longint'(b) <<< 20) + shift;
         p.pos_i[k] = pj[POS_W-1:0];
         p.base[k] = b[BASE_W-1:0];
      end
      return p;
   endfunction

   function automatic logic [ROW_W-1:0] pack_row(int x, int y, int z);
      return {z[LAT_W-1:0], y[LAT_W-1:0], x[LAT_W-1:0]};
   endfunction

   // Writes every register for one setting.
   task automatic apply_setting(int s);
      logic [2:0][ROW_W-1:0] rows;
      logic [2:0][PER_W-1:0] per;
      logic                  mode;
      logic [TOL_W-1:0]      tol;
      case (s)
         0: begin
            rows = {pack_row(0, 0, 1024), pack_row(0, 1024, 0), pack_row(1024, 0, 0)};
            per = {3{8'd1}};
            mode = MODE_TIES;
            tol = '0;
         end
         1, 5: begin
            for (int r = 0; r < 3; r++) rows[r] = ROW_W'({$urandom, $urandom});
            for (int k = 0; k < 3; k++) per[k] = PER_W'($urandom_range(255, 1));
            mode = (s == 5) ? MODE_TIES : MODE_SINGLE;
            tol = $urandom;
         end
         2: begin
            rows = {3{pack_row(1048575, 1048575, 1048575)}};
            per = {3{8'd255}};
            mode = MODE_SINGLE;
            tol = $urandom;
         end
         3: begin
            rows = {3{pack_row(-1048576, -1048576, -1048576)}};
            per = '0;
            mode = MODE_TIES;
            tol = '1;
         end
         4: begin
            rows = {pack_row(0, 0, 1), pack_row(0, 1, 0), pack_row(1, 0, 0)};
            per = {3{8'd2}};
            mode = MODE_TIES;
            tol = $urandom_range(4096);
         end
         6: begin
            rows = {pack_row(-300, 0, 2048), pack_row(0, 1024, 0), pack_row(1536, 0, 0)};
            for (int k = 0; k < 3; k++) per[k] = PER_W'($urandom_range(4, 1));
            mode = MODE_TIES;
            tol = '0;
         end
         default: begin
            rows = '0;
            per = {3{8'd1}};
            mode = MODE_SINGLE;
            tol = '0;
         end
      endcase
      set_reg(CSR_LAT_A, rows[0]);
      set_reg(CSR_LAT_B, rows[1]);
      set_reg(CSR_LAT_C, rows[2]);
      set_reg(CSR_PER_A, CSR_DATA_W'(per[0]));
      set_reg(CSR_PER_B, CSR_DATA_W'(per[1]));
      set_reg(CSR_PER_C, CSR_DATA_W'(per[2]));
      set_reg(CSR_MODE, CSR_DATA_W'(mode));
      set_reg(CSR_TOL, CSR_DATA_W'(tol));
      // A write past the register list must change nothing.
      set_reg(CSR_UNUSED, CSR_DATA_W'({$urandom, $urandom}));
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending_images.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      pair_type directed[$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes and exact ties at half a cell.
      directed = {directed, make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_pair(8388607, 8388607, 8388607,
                                      -8388608, -8388608, -8388608, 127, 127, 127)};
      directed = {directed, make_pair(-8388608, -8388608, -8388608,
                                      8388607, 8388607, 8388607, -128, -128, -128)};
      directed = {directed, make_pair(0, 0, 0, 0, 0, 0, -128, 127, -128)};
      directed = {directed, make_pair(524288, 0, 0, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_pair(524288, 524288, 524288, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_pair(-524288, 524288, -524288, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_pair(1572864, 0, -1572864, 0, 0, 0, 1, 0, -1)};
      directed = {directed, make_pair(1, -1, 2, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_pair(8388607, -8388608, 0, 0, 8388607, -8388608,
                                      7, -8, 0)};

      for (int s = 0; s < 8; s++) begin
         wait_drained();
         apply_setting(s);
         req_idle_pct = (s % 4 == 1 || s % 4 == 3) ? ((s % 4 == 1) ? 72 : 6) : 0;
         rsp_stall_pct = (s % 4 == 2 || s % 4 == 3) ? ((s % 4 == 2) ? 72 : 6) : 0;
         if (s == 0) begin
            foreach (directed[q]) send_pair(directed[q]);
         end
         for (int n = 0; n < 45; n++) send_pair(random_pair());
         req_push <= 1'b0;
      end

      wait_drained();
      if (sb.errors == 0) begin
         $display("** nearest_periodic_image_search_top: PASSED **");
      end else begin
         $display("** nearest_periodic_image_search_top: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/nps_pkg.sv
hw/rtl/nps_front.sv
hw/rtl/nps_eval.sv
hw/rtl/nps_select.sv
hw/rtl/nearest_periodic_image_search_top.sv
hw/rtl/nps_checker.sv
tb/sv/nearest_periodic_image_search_top_tb.sv
